// ===== design/theora_rtp_fragmenter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THEORA_RTP_FRAGMENTER_CORE_MACROS_SVH
`define THEORA_RTP_FRAGMENTER_CORE_MACROS_SVH

// same-cycle implication
`define TRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/trf_pkg.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter package
// Shared constants, codes and the queue word between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trf_pkg;

	localparam int FRAME_SIZE_BITS_DEF = 20;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam logic [23:0] CONFIG_IDENT_RST = 24'h011983;
	localparam logic [15:0] MAX_FRAGMENT_RST = 16'd900;

	localparam int HDR_LEN = 6;
	localparam int IDX_BITS = 3;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIG_IDENT = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FRAGMENT = 1'd1;

	typedef enum logic [1:0] {
		FT_WHOLE = 2'd0,
		FT_START = 2'd1,
		FT_CONT  = 2'd2,
		FT_END   = 2'd3
	} frag_type_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        opens;
		logic [23:0] ident;
		logic [7:0]  type_byte;
		logic [15:0] pay;
		logic        eop;
		logic        fm;
	} entry_t;

endpackage

// ===== design/trf_queue.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter queue
// Small register FIFO between the classifier and the packet emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trf_queue #(
	parameter int DEPTH = trf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  trf_pkg::entry_t push_word,
	input  logic            pop,
	output trf_pkg::entry_t head_word,
	output logic            empty,
	output logic            full
);
	import trf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNTW'(DEPTH));
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== design/trf_front.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter front end
// Holds the registers and frame/packet counters, classifies each input byte
// and builds the queue word with its header fields and end flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trf_front #(
	parameter int FRAME_SIZE_BITS = trf_pkg::FRAME_SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [trf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [trf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               accept,
	input  logic [7:0]                         data_byte,
	input  logic [1:0]                         payload_type,
	input  logic [19:0]                        frame_size,
	output trf_pkg::entry_t                    word
);
	import trf_pkg::*;

	localparam int FSB = FRAME_SIZE_BITS;
	localparam int CW  = (FSB > 16) ? FSB : 16;

	logic [23:0]    ident_q;
	logic [15:0]    max_frag_q;
	logic [FSB-1:0] fbl_q;
	logic [15:0]    pbl_q;
	logic           frag_q;
	logic           first_q;
	logic [1:0]     type_q;

	logic           new_frame;
	logic [FSB-1:0] fs_raw;
	logic [FSB-1:0] fs_nz;
	logic [FSB-1:0] fbl_eff;
	logic [15:0]    mf;
	logic [CW-1:0]  mf_w;
	logic [CW-1:0]  fbl_w;
	logic [CW-1:0]  pay_w;
	logic           frag;
	logic           first;
	logic [1:0]     typ;
	logic [15:0]    pbl_eff;
	logic           opens;
	frag_type_t     ftype;
	logic [15:0]    pbl_next;
	logic [FSB-1:0] fbl_next;

	always_comb begin
		new_frame = (fbl_q == '0);
		fs_raw    = FSB'(frame_size);
		fs_nz     = (fs_raw == '0) ? FSB'(1) : fs_raw;
		fbl_eff   = new_frame ? fs_nz : fbl_q;
		mf        = (max_frag_q == '0) ? 16'd1 : max_frag_q;
		mf_w      = CW'(mf);
		fbl_w     = CW'(fbl_eff);
		frag      = new_frame ? (fbl_w > mf_w) : frag_q;
		first     = new_frame | first_q;
		typ       = new_frame ? payload_type : type_q;
		pbl_eff   = new_frame ? 16'd0 : pbl_q;
		opens     = (pbl_eff == 16'd0);
		pay_w     = (fbl_w < mf_w) ? fbl_w : mf_w;

		priority if (!frag) begin
			ftype = FT_WHOLE;
		end else if (first) begin
			ftype = FT_START;
		end else if (fbl_w <= mf_w) begin
			ftype = FT_END;
		end else begin
			ftype = FT_CONT;
		end

		pbl_next = (opens ? pay_w[15:0] : pbl_eff) - 16'd1;
		fbl_next = fbl_eff - FSB'(1);

		word.data      = data_byte;
		word.opens     = opens;
		word.ident     = ident_q;
		word.type_byte = {ftype, typ, 3'b000, !frag};
		word.pay       = pay_w[15:0];
		word.eop       = (pbl_next == 16'd0);
		word.fm        = (fbl_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q    <= CONFIG_IDENT_RST;
			max_frag_q <= MAX_FRAGMENT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CONFIG_IDENT: ident_q    <= cfg_data[23:0];
				REG_MAX_FRAGMENT: max_frag_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbl_q   <= '0;
			pbl_q   <= '0;
			frag_q  <= 1'b0;
			first_q <= 1'b1;
			type_q  <= '0;
		end else if (accept) begin
			fbl_q   <= fbl_next;
			pbl_q   <= pbl_next;
			frag_q  <= frag;
			first_q <= first & !opens;
			type_q  <= typ;
		end
	end

endmodule

// ===== design/trf_back.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter back end
// Expands each queue word into six header words plus the data word, or the
// data word alone, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  trf_pkg::entry_t head_word,
	input  logic            head_valid,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            start_of_packet,
	output logic            end_of_packet,
	output logic            frame_marker,
	output logic            last_of_item
);
	import trf_pkg::*;

	logic [IDX_BITS-1:0] idx_q;
	logic                valid_q;
	logic [7:0]          byte_q;
	logic                sop_q;
	logic                eop_q;
	logic                fm_q;
	logic                last_q;

	logic                load;
	logic                in_hdr;
	logic [7:0]          hdr_byte;

	always_comb begin
		load   = head_valid && (!valid_q || out_ready);
		in_hdr = head_word.opens && (idx_q < IDX_BITS'(HDR_LEN));
		pop    = load && !in_hdr;
		unique case (idx_q)
			3'd0:    hdr_byte = head_word.ident[23:16];
			3'd1:    hdr_byte = head_word.ident[15:8];
			3'd2:    hdr_byte = head_word.ident[7:0];
			3'd3:    hdr_byte = head_word.type_byte;
			3'd4:    hdr_byte = head_word.pay[15:8];
			default: hdr_byte = head_word.pay[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= in_hdr ? idx_q + IDX_BITS'(1) : '0;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= in_hdr ? hdr_byte : head_word.data;
			sop_q  <= in_hdr && (idx_q == '0);
			eop_q  <= !in_hdr && head_word.eop;
			fm_q   <= !in_hdr && head_word.fm;
			last_q <= !in_hdr;
		end
	end

	assign out_valid       = valid_q;
	assign out_byte        = byte_q;
	assign start_of_packet = sop_q;
	assign end_of_packet   = eop_q;
	assign frame_marker    = fm_q;
	assign last_of_item    = last_q;

endmodule

// ===== design/theora_rtp_fragmenter_core.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter core
// Cuts a byte-serial encoded frame into Theora RTP payload packets.
// ----------------------------------------------------------------------------
// One input word per cycle is accepted while the queue has room. The first
// byte of a packet yields seven output words (six header words, then the
// byte), every other byte one word, so a packet of N data bytes yields N + 6
// words; the single output port sets the sustained rate. Accepted words pass
// through the queue into the registered output stage; the QUEUE_DEPTH-word
// queue lets the input run ahead during header output. Registers are read at
// each packet start; the user must write them only while idle (unenforced).
`timescale 1ns / 1ps

module theora_rtp_fragmenter_core #(
	parameter int FRAME_SIZE_BITS = trf_pkg::FRAME_SIZE_BITS_DEF,
	parameter int QUEUE_DEPTH     = trf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [trf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [trf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic [1:0]                         payload_type,
	input  logic [19:0]                        frame_size,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         out_byte,
	output logic                               start_of_packet,
	output logic                               end_of_packet,
	output logic                               frame_marker,
	output logic                               last_of_item
);
	import trf_pkg::*;

	entry_t push_word;
	entry_t head_word;
	logic   accept;
	logic   pop;
	logic   empty;
	logic   full;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign accept    = in_valid && !full;

	trf_front #(
		.FRAME_SIZE_BITS(FRAME_SIZE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.data_byte   (data_byte),
		.payload_type(payload_type),
		.frame_size  (frame_size),
		.word        (push_word)
	);

	trf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_word(push_word),
		.pop      (pop),
		.head_word(head_word),
		.empty    (empty),
		.full     (full)
	);

	trf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_word      (head_word),
		.head_valid     (!empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.start_of_packet(start_of_packet),
		.end_of_packet  (end_of_packet),
		.frame_marker   (frame_marker),
		.last_of_item   (last_of_item)
	);

endmodule

// ===== design/trf_checker.sv =====
// ----------------------------------------------------------------------------
// Theora RTP fragmenter checker
// Port-level assertions on the output word stream, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "theora_rtp_fragmenter_core_macros.svh"

module trf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       start_of_packet,
	input logic       end_of_packet,
	input logic       frame_marker,
	input logic       last_of_item
);

	`TRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(last_of_item), "output word changed while stalled")
	`TRF_ASSERT_NOW(a_sop_is_header, out_valid && start_of_packet,
		!last_of_item && !end_of_packet, "packet start flagged on a data word")
	`TRF_ASSERT_NOW(a_marker_ends, out_valid && (frame_marker || end_of_packet),
		last_of_item && (end_of_packet || !frame_marker), "frame marker off a packet end")
	`TRF_ASSERT_NEXT(a_hdr_runs, out_valid && out_ready && start_of_packet,
		out_valid && !start_of_packet && !last_of_item, "header broken after packet start")

endmodule

bind theora_rtp_fragmenter_core trf_checker u_trf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.out_byte       (out_byte),
	.start_of_packet(start_of_packet),
	.end_of_packet  (end_of_packet),
	.frame_marker   (frame_marker),
	.last_of_item   (last_of_item)
);
